@@ hw/rtl/vtn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtn_pkg: shared types and constants
// Item structs, mode and function codes for the vertex transform block.
// ----------------------------------------------------------------------------
package vtn_pkg;

  localparam int FracBitsDefault = 16;

  localparam logic [2:0] MODE_SCALE   = 3'd0;
  localparam logic [2:0] MODE_MOVE_X  = 3'd1;
  localparam logic [2:0] MODE_MOVE_Y  = 3'd2;
  localparam logic [2:0] MODE_MOVE_Z  = 3'd3;
  localparam logic [2:0] MODE_ROT_YZ  = 3'd4;
  localparam logic [2:0] MODE_ROT_XZ  = 3'd5;
  localparam logic [2:0] MODE_ROT_XY  = 3'd6;

  localparam logic [1:0] FUNC_XFORM = 2'd0;
  localparam logic [1:0] FUNC_ACCUM = 2'd1;
  localparam logic [1:0] FUNC_NORM  = 2'd2;

  localparam logic [1:0] REG_OP_MODE = 2'd0;
  localparam logic [1:0] REG_AMOUNT  = 2'd1;
  localparam logic [1:0] REG_COS     = 2'd2;
  localparam logic [1:0] REG_SIN     = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic               first_of_object;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } vtn_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               fault;
  } vtn_out_t;

endpackage

@@ hw/rtl/vertex_transform_normalize_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_transform_normalize_top: vertex transform and box normalization
// Transform and normalize run the multiply steps and a rounding step from accept
// to result valid, after the serial divider when the scale factor is recomputed.
// Accumulate updates the box and gives no result.
// One item at a time; the next item is accepted the cycle after the result
// is taken. One shared 33x33 multiplier, one product per cycle.
// Synchronous reset sets the configuration defaults and clears the box and scale state.
// ----------------------------------------------------------------------------
module vertex_transform_normalize_top #(
  parameter int FRAC_BITS = vtn_pkg::FracBitsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  vtn_pkg::vtn_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output vtn_pkg::vtn_out_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import vtn_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_MUL, S_FIN, S_OUT} state_t;

  state_t state;
  logic [2:0]         op_mode;
  logic signed [31:0] amount;
  logic signed [17:0] cos_value, sin_value;
  logic signed [31:0] box_min [3];
  logic signed [31:0] box_max [3];
  logic [31:0]        norm_scale;
  logic               scale_ready;
  vtn_in_t            item;
  logic [2:0]         step;
  logic [1:0]         sel;
  logic signed [65:0] acc [3];
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  logic signed [33:0] dvec [3];
  logic [31:0]        res [3];
  logic               flt;
  logic               div_start, div_done;
  logic [66:0]        div_quo;
  logic [32:0]        dmax;
  logic [32:0]        span [3];
  logic [66:0]        div_num;
  logic [34:0]        div_den;
  logic signed [31:0] vin [3];

  assign vin[0] = item.coord_x;
  assign vin[1] = item.coord_y;
  assign vin[2] = item.coord_z;

  assign sel = (step[1:0] == 2'd3) ? 2'd0 : step[1:0];

  function automatic logic [31:0] sat_v(input logic signed [65:0] v, output logic f);
    f = 1'b0;
    if (v > 66'sd2147483647) begin
      f = 1'b1; sat_v = 32'h7FFFFFFF;
    end else if (v < -66'sd2147483648) begin
      f = 1'b1; sat_v = 32'h80000000;
    end else begin
      sat_v = v[31:0];
    end
  endfunction

  function automatic logic signed [65:0] rnd(input logic signed [65:0] v);
    logic [65:0] m;
    m = v[65] ? 66'(-v) : 66'(v);
    m = (m + (66'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    rnd = v[65] ? -$signed(m) : $signed(m);
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      span[i] = 33'(box_max[i]) - 33'(box_min[i]);
      dvec[i] = 34'(vin[i]) - ((34'(box_max[i]) + 34'(box_min[i])) >>> 1);
    end
    dmax = span[0];
    if (span[1] > dmax) dmax = span[1];
    if (span[2] > dmax) dmax = span[2];
    div_num = (67'd7 << (2 * FRAC_BITS)) + 67'({dmax, 2'b0} + 35'(dmax)) / 67'd2;
    div_den = {dmax, 2'b0} + 35'(dmax);
  end

  // operand select for the shared multiplier, one product per step
  always_comb begin
    ma = '0;
    mb = '0;
    if (item.func == FUNC_NORM) begin
      ma = 33'(dvec[sel]);
      mb = $signed({1'b0, norm_scale});
    end else begin
      unique case (op_mode)
        MODE_SCALE: begin ma = 33'(vin[sel]); mb = 33'(amount); end
        MODE_ROT_YZ: unique case (step)
          3'd0: begin ma = 33'(vin[1]); mb = 33'(cos_value); end
          3'd1: begin ma = 33'(vin[2]); mb = -33'(sin_value); end
          3'd2: begin ma = 33'(vin[1]); mb = 33'(sin_value); end
          default: begin ma = 33'(vin[2]); mb = 33'(cos_value); end
        endcase
        MODE_ROT_XZ: unique case (step)
          3'd0: begin ma = 33'(vin[0]); mb = 33'(cos_value); end
          3'd1: begin ma = 33'(vin[2]); mb = 33'(sin_value); end
          3'd2: begin ma = 33'(vin[0]); mb = -33'(sin_value); end
          default: begin ma = 33'(vin[2]); mb = 33'(cos_value); end
        endcase
        default: unique case (step)
          3'd0: begin ma = 33'(vin[0]); mb = 33'(cos_value); end
          3'd1: begin ma = 33'(vin[1]); mb = -33'(sin_value); end
          3'd2: begin ma = 33'(vin[0]); mb = 33'(sin_value); end
          default: begin ma = 33'(vin[1]); mb = 33'(cos_value); end
        endcase
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  vtn_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  assign in_ready = (state == S_IDLE);
  assign out_data = '{res[0], res[1], res[2], flt};

  always_ff @(posedge clk) begin
    logic f0, f1, f2, fl;
    logic [31:0] s0, s1, s2, r0, r1, r2;
    if (rst) begin
      state <= S_IDLE;
      op_mode <= MODE_SCALE;
      amount <= 32'sd1 <<< FRAC_BITS;
      cos_value <= 18'sd1 <<< FRAC_BITS;
      sin_value <= '0;
      for (int i = 0; i < 3; i++) begin
        box_min[i] <= '0;
        box_max[i] <= '0;
      end
      norm_scale <= '0;
      scale_ready <= 1'b0;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      step <= '0;
    end else begin
      div_start <= (state == S_IDLE) && in_valid && (in_data.func == FUNC_NORM) &&
                   !scale_ready;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_OP_MODE: op_mode <= cfg_data[2:0];
          REG_AMOUNT:  amount <= cfg_data;
          REG_COS:     cos_value <= cfg_data[17:0];
          default:     sin_value <= cfg_data[17:0];
        endcase
      end
      unique case (state)
        S_IDLE: if (in_valid) begin
          item <= in_data;
          step <= '0;
          for (int i = 0; i < 3; i++) acc[i] <= '0;
          flt <= 1'b0;
          unique case (in_data.func)
            FUNC_ACCUM: begin
              scale_ready <= 1'b0;
              for (int i = 0; i < 3; i++) begin
                logic signed [31:0] lo, hi, c;
                lo = in_data.first_of_object ? 32'sd0 : box_min[i];
                hi = in_data.first_of_object ? 32'sd0 : box_max[i];
                c = (i == 0) ? in_data.coord_x :
                    (i == 1) ? in_data.coord_y : in_data.coord_z;
                box_min[i] <= (c < lo) ? c : lo;
                box_max[i] <= (c > hi) ? c : hi;
              end
            end
            FUNC_NORM: begin
              if (!scale_ready) state <= S_DIV;
              else state <= S_MUL;
            end
            FUNC_XFORM: state <= S_MUL;
            default: ;
          endcase
        end
        S_DIV: if (div_done) begin
          scale_ready <= 1'b1;
          if (dmax == '0) norm_scale <= '0;
          else if (div_quo > 67'h7FFFFFFF) norm_scale <= 32'h7FFFFFFF;
          else norm_scale <= div_quo[31:0];
          state <= S_MUL;
        end
        S_MUL: begin
          step <= step + 3'd1;
          if (step != 3'd0) begin
            if (item.func == FUNC_NORM || op_mode == MODE_SCALE) begin
              if (step != 3'd4) acc[2'(step - 3'd1)] <= prod;
            end else if (step < 3'd3) acc[0] <= acc[0] + prod;
            else acc[1] <= acc[1] + prod;
          end
          if (step == 3'd4) state <= S_FIN;
        end
        S_FIN: begin
          r0 = vin[0];
          r1 = vin[1];
          r2 = vin[2];
          fl = 1'b0;
          if (item.func == FUNC_NORM) begin
            if (norm_scale == '0) begin
              r0 = sat_v(66'(dvec[0]), f0);
              r1 = sat_v(66'(dvec[1]), f1);
              r2 = sat_v(66'(dvec[2]), f2);
              fl = 1'b1;
            end else begin
              r0 = sat_v(rnd(acc[0]), f0);
              r1 = sat_v(rnd(acc[1]), f1);
              r2 = sat_v(rnd(acc[2]), f2);
              fl = f0 | f1 | f2;
            end
          end else begin
            s0 = sat_v(rnd(acc[0]), f0);
            s1 = sat_v(rnd(acc[1]), f1);
            s2 = sat_v(rnd(acc[2]), f2);
            unique case (op_mode)
              MODE_SCALE: begin
                r0 = s0; r1 = s1; r2 = s2;
                fl = f0 | f1 | f2;
              end
              MODE_MOVE_X: r0 = sat_v(66'(vin[0]) + 66'(amount), fl);
              MODE_MOVE_Y: r1 = sat_v(66'(vin[1]) + 66'(amount), fl);
              MODE_MOVE_Z: r2 = sat_v(66'(vin[2]) + 66'(amount), fl);
              MODE_ROT_YZ: begin r1 = s0; r2 = s1; fl = f0 | f1; end
              MODE_ROT_XZ: begin r0 = s0; r2 = s1; fl = f0 | f1; end
              MODE_ROT_XY: begin r0 = s0; r1 = s1; fl = f0 | f1; end
              default: ;
            endcase
          end
          res[0] <= r0;
          res[1] <= r1;
          res[2] <= r2;
          flt <= fl;
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ hw/rtl/vtn_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtn_div: radix-2 restoring divider
// Unsigned 67 by 35 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vtn_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [66:0] num,
  input  logic [34:0] den,
  output logic        done,
  output logic [66:0] quo
);
  logic [66:0] q;
  logic [35:0] rem;
  logic [6:0]  cnt;
  logic        busy;
  logic [35:0] trial;

  always_comb begin
    trial = {rem[34:0], q[66]} - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q    <= num;
        rem  <= '0;
        cnt  <= 7'd67;
      end else if (busy) begin
        if (!trial[35]) begin
          rem <= trial;
          q   <= {q[65:0], 1'b1};
        end else begin
          rem <= {rem[34:0], q[66]};
          q   <= {q[65:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = q;
endmodule

@@ sim/tb_vertex_transform_normalize_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vertex_transform_normalize_top: vertex transform block testbench
// Drives vertex items through the transform, box and normalize functions under
// every mode, predicts each result in fixed point and compares the whole output word.
// ----------------------------------------------------------------------------
module tb_vertex_transform_normalize_top;
  import vtn_pkg::*;

  localparam int FB = FracBitsDefault;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  vtn_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  vtn_out_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  vertex_transform_normalize_top #(.FRAC_BITS(FB)) uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [2:0] mode_q;
  logic signed [63:0] amt_q, cos_q, sin_q;
  logic signed [31:0] bmin[3], bmax[3];
  logic [31:0] nscale;
  bit scale_ok;
  vtn_out_t expected_q[$];
  int mismatches = 0;

  function automatic logic [31:0] clamp32(logic signed [127:0] v, inout bit f);
    if (v > 128'sd2147483647) begin
      f = 1; return 32'h7fffffff;
    end
    if (v < -128'sd2147483648) begin
      f = 1; return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] round_clamp(logic signed [127:0] v, inout bit f);
    logic signed [127:0] m, r;
    m = (v < 0) ? -v : v;
    r = (m + (128'sd1 <<< (FB - 1))) >>> FB;
    return clamp32((v < 0) ? -r : r, f);
  endfunction

  function automatic bit predict_vertex(vtn_in_t it, output vtn_out_t res);
    logic signed [127:0] v[3], s, d, ctr;
    logic [31:0] r[3];
    logic [63:0] dmax, span, q, den;
    bit f;
    f = 0;
    v[0] = it.coord_x; v[1] = it.coord_y; v[2] = it.coord_z;
    for (int i = 0; i < 3; i++) r[i] = v[i][31:0];
    case (it.func)
      FUNC_XFORM: begin
        case (mode_q)
          MODE_SCALE: for (int i = 0; i < 3; i++) r[i] = round_clamp(v[i] * amt_q, f);
          MODE_MOVE_X, MODE_MOVE_Y, MODE_MOVE_Z:
            r[mode_q - 1] = clamp32(v[mode_q - 1] + amt_q, f);
          MODE_ROT_YZ: begin
            r[1] = round_clamp(v[1] * cos_q - v[2] * sin_q, f);
            r[2] = round_clamp(v[1] * sin_q + v[2] * cos_q, f);
          end
          MODE_ROT_XZ: begin
            r[0] = round_clamp(v[0] * cos_q + v[2] * sin_q, f);
            r[2] = round_clamp(v[2] * cos_q - v[0] * sin_q, f);
          end
          MODE_ROT_XY: begin
            r[0] = round_clamp(v[0] * cos_q - v[1] * sin_q, f);
            r[1] = round_clamp(v[0] * sin_q + v[1] * cos_q, f);
          end
          default: ;
        endcase
      end
      FUNC_ACCUM: begin
        for (int i = 0; i < 3; i++) begin
          if (it.first_of_object) begin
            bmin[i] = 0; bmax[i] = 0;
          end
          if (v[i] < bmin[i]) bmin[i] = v[i][31:0];
          if (v[i] > bmax[i]) bmax[i] = v[i][31:0];
        end
        scale_ok = 0;
        return 0;
      end
      FUNC_NORM: begin
        if (!scale_ok) begin
          dmax = 0;
          for (int i = 0; i < 3; i++) begin
            span = 64'(bmax[i] - 64'sd0) - 64'(bmin[i] - 64'sd0);
            if (span > dmax) dmax = span;
          end
          if (dmax == 0) nscale = 0;
          else begin
            den = dmax * 5;
            q = ((64'd7 << (2 * FB)) + den / 2) / den;
            nscale = (q > 64'h7fffffff) ? 32'h7fffffff : q[31:0];
          end
          scale_ok = 1;
        end
        for (int i = 0; i < 3; i++) begin
          s = 128'(bmax[i]) + 128'(bmin[i]);
          ctr = (s >= 0) ? s / 2 : -((-s + 1) / 2);
          d = v[i] - ctr;
          if (nscale == 0) r[i] = clamp32(d, f);
          else r[i] = round_clamp(d * $signed({1'b0, nscale}), f);
        end
        if (nscale == 0) f = 1;
      end
      default: return 0;
    endcase
    res.out_x = r[0]; res.out_y = r[1]; res.out_z = r[2]; res.fault = f;
    return 1;
  endfunction

  task automatic send_vertex(logic [1:0] fn, bit first, logic [31:0] x, y, z);
    vtn_in_t it;
    vtn_out_t res;
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    it.func = fn; it.first_of_object = first;
    it.coord_x = x; it.coord_y = y; it.coord_z = z;
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (predict_vertex(it, res)) expected_q.push_back(res);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_OP_MODE: mode_q = val[2:0];
      REG_AMOUNT: amt_q = $signed(val);
      REG_COS: cos_q = $signed(val[17:0]);
      default: sin_q = $signed(val[17:0]);
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] any_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 8) << 16;
      3: return $urandom();
      default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  function automatic logic [17:0] any_trig();
    case ($urandom_range(0, 3))
      0: return 18'd65536;
      1: return 18'h30000;
      default: return 18'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  task automatic test_directed();
    send_vertex(FUNC_NORM, 1'b0, 32'h10000, 0, 0);
    send_vertex(FUNC_XFORM, 1'b0, 32'h7fffffff, 32'h80000000, 32'h12345);
    write_reg(REG_AMOUNT, 32'h7fffffff);
    send_vertex(FUNC_XFORM, 1'b0, 32'h7fffffff, 32'h80000000, 32'hffff8000);
    write_reg(REG_AMOUNT, 32'h80000000);
    send_vertex(FUNC_XFORM, 1'b0, 32'h7fffffff, 32'h80000000, 32'h00008000);
    for (int m = 1; m < 8; m++) begin
      write_reg(REG_OP_MODE, 32'(m));
      send_vertex(FUNC_XFORM, 1'b0, 32'h7fffffff, 32'h80000000, 32'h80000000);
    end
    write_reg(REG_COS, 32'h30000);
    write_reg(REG_SIN, 32'd65536);
    write_reg(REG_OP_MODE, 32'(MODE_ROT_XY));
    send_vertex(FUNC_XFORM, 1'b0, 32'h80000000, 32'h80000000, 1);
    send_vertex(FUNC_ACCUM, 1'b1, 32'h80000000, 32'h7fffffff, 0);
    send_vertex(FUNC_NORM, 1'b0, 32'h7fffffff, 32'h80000000, 0);
    send_vertex(FUNC_ACCUM, 1'b1, 1, 1, 0);
    send_vertex(FUNC_NORM, 1'b0, 5, 32'h80000000, 32'h7fffffff);
    send_vertex(2'd3, 1'b1, 1, 2, 3);
    send_vertex(FUNC_XFORM, 1'b1, 4, 5, 6);
  endtask

  task automatic test_random();
    int n;
    n = 0;
    while (n < 1350) begin
      case ($urandom_range(0, 4))
        0: write_reg(REG_OP_MODE, $urandom_range(0, 7));
        1: write_reg(REG_AMOUNT, any_coord());
        2: write_reg(REG_COS, {14'd0, any_trig()});
        default: write_reg(REG_SIN, {14'd0, any_trig()});
      endcase
      repeat ($urandom_range(5, 25)) begin
        send_vertex(FUNC_XFORM, 1'($urandom_range(0, 1)),
                    any_coord(), any_coord(), any_coord());
        n++;
      end
      repeat ($urandom_range(1, 6)) begin
        send_vertex(FUNC_ACCUM, n % 3 == 0, any_coord(), any_coord(), any_coord());
        n++;
      end
      repeat ($urandom_range(1, 8)) begin
        send_vertex($urandom_range(0, 9) == 0 ? 2'd3 : FUNC_NORM,
                    1'($urandom_range(0, 1)), any_coord(), any_coord(), any_coord());
        n++;
      end
    end
  endtask

  always begin
    int w;
    w = $urandom_range(0, 5);
    @(negedge clk);
    if (!out_valid || w != 0) out_ready <= 1'b0;
    while (!out_valid) @(negedge clk);
    repeat (w) @(negedge clk);
    out_ready <= 1'b1;
    @(posedge clk);
  end

  always @(posedge clk) begin
    vtn_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: %p", out_data);
      end else begin
        want = expected_q.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("expected %p got %p", want, out_data);
        end
      end
    end
  end

  initial begin
    mode_q = MODE_SCALE; amt_q = 64'sd65536; cos_q = 64'sd65536; sin_q = 0;
    for (int i = 0; i < 3; i++) begin
      bmin[i] = 0; bmax[i] = 0;
    end
    nscale = 0; scale_ok = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (mismatches == 0 && expected_q.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/vtn_pkg.sv
hw/rtl/vtn_div.sv
hw/rtl/vertex_transform_normalize_top.sv
sim/tb_vertex_transform_normalize_top.sv
